@@ rtl/mwe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwe_pkg
// Shared constants, types and helpers for the masked window erosion block.
// ----------------------------------------------------------------------------
package mwe_pkg;

  // geometry limits
  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int MASK_W     = 49;
  localparam int KSZ_W      = 3;
  localparam int IMGW_W     = 11;
  localparam int IMGH_W     = 13;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [PIX_W-1:0] EMPTY_MIN = 8'hFF;

  // register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_SIZE  = 2'd2;
  localparam logic [1:0] REG_KERNEL_MASK  = 2'd3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [MAX_KERNEL-1:0] column_t;   // element j is row r-j
  typedef pix_t [MAX_KERNEL-2:0] hist_t;     // older rows kept per column
  typedef column_t [MAX_KERNEL-1:0] window_t; // element i is column c-i

  // position tag carried alongside each request
  typedef struct packed {
    logic             res;
    logic [ROW_W-1:0] top;
    logic [COL_W-1:0] left;
    logic             done;
  } meta_t;

  typedef struct packed {
    pix_t             value;
    logic [ROW_W-1:0] top;
    logic [COL_W-1:0] left;
    logic             done;
  } result_t;

  // mask bit for window cell (row r-j, column c-i), zero outside the kernel
  function automatic logic [MASK_W-1:0] eff_mask(input logic [KSZ_W-1:0] k,
                                                 input logic [MASK_W-1:0] m);
    logic [MASK_W-1:0] e;
    int dy;
    int dx;
    e = '0;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        if (j < int'(k) && i < int'(k)) begin
          dy = int'(k) - 1 - j;
          dx = int'(k) - 1 - i;
          e[j*MAX_KERNEL+i] = m[dy*MAX_KERNEL+dx];
        end
      end
    end
    return e;
  endfunction

endpackage

@@ rtl/mwe_line_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwe_line_buf
// Column history store: one entry per image column holding the pixels of
// the previous rows, read and shifted back once per incoming pixel.
// ----------------------------------------------------------------------------
module mwe_line_buf (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [mwe_pkg::COL_W-1:0]  req_addr,
  input  mwe_pkg::pix_t              req_pixel,
  output logic                       col_valid,
  output mwe_pkg::column_t           col
);

  mwe_pkg::hist_t mem [mwe_pkg::MAX_WIDTH];
  mwe_pkg::hist_t rd_data;

  logic                      s_valid;
  logic [mwe_pkg::COL_W-1:0] s_addr;
  mwe_pkg::pix_t             s_pixel;

  logic                      fwd_valid;
  logic [mwe_pkg::COL_W-1:0] fwd_addr;
  mwe_pkg::hist_t            fwd_data;

  mwe_pkg::hist_t old_hist;
  mwe_pkg::hist_t new_hist;

  // registered memory read, and write-back of the new history
  always_ff @(posedge clk) begin
    if (req_valid) begin
      rd_data <= mem[req_addr];
    end
    if (s_valid) begin
      mem[s_addr] <= new_hist;
    end
  end

  // request stage alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s_valid   <= req_valid;
      fwd_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    s_addr   <= req_addr;
    s_pixel  <= req_pixel;
    fwd_addr <= s_addr;
    fwd_data <= new_hist;
  end

  // write at the same edge as the read is missed by it, so bypass
  always_comb begin
    old_hist = rd_data;
    if (fwd_valid && fwd_addr == s_addr) begin
      old_hist = fwd_data;
    end
    new_hist[0] = s_pixel;
    for (int j = 1; j < mwe_pkg::MAX_KERNEL - 1; j++) begin
      new_hist[j] = old_hist[j-1];
    end
    col[0] = s_pixel;
    for (int j = 1; j < mwe_pkg::MAX_KERNEL; j++) begin
      col[j] = old_hist[j-1];
    end
  end

  assign col_valid = s_valid;

endmodule

@@ rtl/mwe_min_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwe_min_tree
// Masked minimum over the window: per-row minima registered, then the
// minimum of the rows.
// ----------------------------------------------------------------------------
module mwe_min_tree (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  mwe_pkg::meta_t             in_meta,
  input  mwe_pkg::window_t           win,
  input  logic [mwe_pkg::MASK_W-1:0] mask,
  output logic                       res_valid,
  output mwe_pkg::meta_t             res_meta,
  output mwe_pkg::pix_t              res_value
);

  mwe_pkg::pix_t row_min      [mwe_pkg::MAX_KERNEL];
  mwe_pkg::pix_t row_min_next [mwe_pkg::MAX_KERNEL];
  mwe_pkg::pix_t cand;
  mwe_pkg::pix_t total;

  // per-row minimum of the selected pixels
  always_comb begin
    cand = mwe_pkg::EMPTY_MIN;
    for (int j = 0; j < mwe_pkg::MAX_KERNEL; j++) begin
      row_min_next[j] = mwe_pkg::EMPTY_MIN;
      for (int i = 0; i < mwe_pkg::MAX_KERNEL; i++) begin
        cand = mask[j*mwe_pkg::MAX_KERNEL+i] ? win[i][j] : mwe_pkg::EMPTY_MIN;
        if (cand < row_min_next[j]) begin
          row_min_next[j] = cand;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_meta <= in_meta;
    for (int j = 0; j < mwe_pkg::MAX_KERNEL; j++) begin
      row_min[j] <= row_min_next[j];
    end
  end

  // minimum across rows
  always_comb begin
    total = mwe_pkg::EMPTY_MIN;
    for (int j = 0; j < mwe_pkg::MAX_KERNEL; j++) begin
      if (row_min[j] < total) begin
        total = row_min[j];
      end
    end
  end

  assign res_value = total;

endmodule

@@ rtl/masked_window_erosion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_window_erosion
// Grayscale erosion with a configurable square structuring element.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the input channel (pixel, in_valid,
// in_stall). Once the bottom-right pixel of a window that fits in the frame
// arrives, the masked minimum leaves on the output channel (eroded_value,
// out_row, out_col, frame_done, out_valid, out_stall), tagged with the
// window's top-left corner; other pixels give no result.
// Throughput is one pixel per clock while in_stall is low. The column history
// memory is read at the pixel's column on acceptance and written back in the
// following cycle, with a bypass for one-pixel-wide frames. A result passes
// the line buffer, window and row minima registers on its way to the queue.
// The output queue holds eight results; in_stall rises when queued plus
// in-flight results would fill it, so a stalled receiver halts the input
// without losing anything.
// Reset clears counters, pipeline and queue and loads 640 x 480, kernel 3,
// full mask. A write of width, height or kernel size restarts the frame;
// a mask write applies from the next result. Write registers only when idle.
// ----------------------------------------------------------------------------
module masked_window_erosion (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [mwe_pkg::MASK_W-1:0]       cfg_data,
  input  logic [mwe_pkg::PIX_W-1:0]        pixel,
  input  logic                             in_valid,
  output logic                             in_stall,
  output logic [mwe_pkg::PIX_W-1:0]        eroded_value,
  output logic [mwe_pkg::ROW_W-1:0]        out_row,
  output logic [mwe_pkg::COL_W-1:0]        out_col,
  output logic                             frame_done,
  output logic                             out_valid,
  input  logic                             out_stall
);

  // configuration registers
  logic [mwe_pkg::IMGW_W-1:0] image_width;
  logic [mwe_pkg::IMGH_W-1:0] image_height;
  logic [mwe_pkg::KSZ_W-1:0]  kernel_size;
  logic [mwe_pkg::MASK_W-1:0] kernel_mask;

  logic [mwe_pkg::IMGW_W-1:0] eff_w;
  logic [mwe_pkg::IMGH_W-1:0] eff_h;
  logic [mwe_pkg::KSZ_W-1:0]  eff_k;
  logic [mwe_pkg::KSZ_W-1:0]  k_less;
  logic [mwe_pkg::MASK_W-1:0] mask_win;

  logic [mwe_pkg::ROW_W-1:0] row_count;
  logic [mwe_pkg::COL_W-1:0] col_count;
  logic [mwe_pkg::ROW_W-1:0] row_count_next;
  logic [mwe_pkg::COL_W-1:0] col_count_next;
  logic                      col_last;
  logic                      row_last;
  logic                      geom_write;

  logic           in_accept;
  mwe_pkg::meta_t meta0;

  logic             col_valid;
  mwe_pkg::column_t col;
  mwe_pkg::meta_t   s1_meta;
  mwe_pkg::window_t win;
  logic             s2_valid;
  mwe_pkg::meta_t   s2_meta;

  logic           tree_valid;
  mwe_pkg::meta_t tree_meta;
  mwe_pkg::pix_t  tree_value;

  mwe_pkg::result_t             fifo_mem [mwe_pkg::FIFO_DEPTH];
  logic [mwe_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [mwe_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [mwe_pkg::FIFO_AW:0]    fifo_count;
  logic                         fifo_push;
  logic                         fifo_pop;
  logic [1:0]                   inflight;
  logic [mwe_pkg::FIFO_AW+1:0]  occupancy;
  mwe_pkg::result_t             head;

  // effective geometry
  always_comb begin
    if (image_width == '0) begin
      eff_w = mwe_pkg::IMGW_W'(1);
    end else if (image_width > mwe_pkg::IMGW_W'(mwe_pkg::MAX_WIDTH)) begin
      eff_w = mwe_pkg::IMGW_W'(mwe_pkg::MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = mwe_pkg::IMGH_W'(1);
    end else if (image_height > mwe_pkg::IMGH_W'(mwe_pkg::MAX_HEIGHT)) begin
      eff_h = mwe_pkg::IMGH_W'(mwe_pkg::MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
    eff_k    = (kernel_size == '0) ? mwe_pkg::KSZ_W'(1) : kernel_size;
    k_less   = eff_k - mwe_pkg::KSZ_W'(1);
    mask_win = mwe_pkg::eff_mask(eff_k, kernel_mask);
  end

  assign geom_write = cfg_we && (cfg_index == mwe_pkg::REG_IMAGE_WIDTH ||
                                 cfg_index == mwe_pkg::REG_IMAGE_HEIGHT ||
                                 cfg_index == mwe_pkg::REG_KERNEL_SIZE);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mwe_pkg::IMGW_W'(640);
      image_height <= mwe_pkg::IMGH_W'(480);
      kernel_size  <= mwe_pkg::KSZ_W'(3);
      kernel_mask  <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        mwe_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[mwe_pkg::IMGW_W-1:0];
        mwe_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[mwe_pkg::IMGH_W-1:0];
        mwe_pkg::REG_KERNEL_SIZE:  kernel_size  <= cfg_data[mwe_pkg::KSZ_W-1:0];
        mwe_pkg::REG_KERNEL_MASK:  kernel_mask  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid && !in_stall;

  // position of the incoming pixel and its window tag
  always_comb begin
    col_last = {1'b0, col_count} == eff_w - mwe_pkg::IMGW_W'(1);
    row_last = {1'b0, row_count} == eff_h - mwe_pkg::IMGH_W'(1);
    meta0.res  = (row_count >= mwe_pkg::ROW_W'(k_less)) &&
                 (col_count >= mwe_pkg::COL_W'(k_less));
    meta0.top  = row_count - mwe_pkg::ROW_W'(k_less);
    meta0.left = col_count - mwe_pkg::COL_W'(k_less);
    meta0.done = row_last && col_last;
    if (col_last) begin
      col_count_next = '0;
      row_count_next = row_last ? '0 : row_count + mwe_pkg::ROW_W'(1);
    end else begin
      col_count_next = col_count + mwe_pkg::COL_W'(1);
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_write) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  mwe_line_buf u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_accept),
    .req_addr  (col_count),
    .req_pixel (pixel),
    .col_valid (col_valid),
    .col       (col)
  );

  // window shift register, newest column first
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_meta <= meta0;
    end
    if (col_valid) begin
      win[0] <= col;
      for (int i = 1; i < mwe_pkg::MAX_KERNEL; i++) begin
        win[i] <= win[i-1];
      end
    end
    s2_meta <= s1_meta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= col_valid && s1_meta.res;
    end
  end

  mwe_min_tree u_min_tree (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_meta   (s2_meta),
    .win       (win),
    .mask      (mask_win),
    .res_valid (tree_valid),
    .res_meta  (tree_meta),
    .res_value (tree_value)
  );

  // output queue with credit for requests still in the pipeline
  assign fifo_push = tree_valid;
  assign fifo_pop  = out_valid && !out_stall;
  assign inflight  = {1'b0, col_valid && s1_meta.res} + {1'b0, s2_valid} +
                     {1'b0, tree_valid};
  assign occupancy = {1'b0, fifo_count} + {{mwe_pkg::FIFO_AW{1'b0}}, inflight};
  assign in_stall  = occupancy >= (mwe_pkg::FIFO_AW+2)'(mwe_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[wr_ptr] <= '{value: tree_value, top: tree_meta.top,
                            left: tree_meta.left, done: tree_meta.done};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr <= wr_ptr + mwe_pkg::FIFO_AW'(1);
      end
      if (fifo_pop) begin
        rd_ptr <= rd_ptr + mwe_pkg::FIFO_AW'(1);
      end
      case ({fifo_push, fifo_pop})
        2'b10:   fifo_count <= fifo_count + (mwe_pkg::FIFO_AW+1)'(1);
        2'b01:   fifo_count <= fifo_count - (mwe_pkg::FIFO_AW+1)'(1);
        default: fifo_count <= fifo_count;
      endcase
    end
  end

  assign head         = fifo_mem[rd_ptr];
  assign out_valid    = fifo_count != '0;
  assign eroded_value = head.value;
  assign out_row      = head.top;
  assign out_col      = head.left;
  assign frame_done   = head.done;

  // checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= (mwe_pkg::FIFO_AW+1)'(mwe_pkg::FIFO_DEPTH))
    else $error("output queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> (fifo_count != (mwe_pkg::FIFO_AW+1)'(mwe_pkg::FIFO_DEPTH)) || fifo_pop)
    else $error("result pushed into full queue");

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col_count} < eff_w)
    else $error("column counter outside frame width");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (in_accept && meta0.res) |-> ##3 fifo_push)
    else $error("window result did not reach queue after three cycles");

endmodule

@@ bench/mwe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwe_checker
// Watches the pixel, result and register ports of the erosion block, keeps
// its own copy of the line history, counters and registers, works out the
// masked window minimum for every window that an accepted pixel completes and
// compares each result request against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module mwe_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mwe_pkg::MASK_W-1:0] cfg_data,
  input  logic [mwe_pkg::PIX_W-1:0]  pixel,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [mwe_pkg::PIX_W-1:0]  eroded_value,
  input  logic [mwe_pkg::ROW_W-1:0]  out_row,
  input  logic [mwe_pkg::COL_W-1:0]  out_col,
  input  logic                       frame_done,
  input  logic                       out_valid,
  input  logic                       out_stall,
  output int                         fail_count,
  output int                         pending
);

  // local copy of the frame history and settings
  mwe_pkg::pix_t              recent_lines [mwe_pkg::MAX_KERNEL*mwe_pkg::MAX_WIDTH];
  int unsigned                img_width;
  int unsigned                img_height;
  int unsigned                win_size;
  logic [mwe_pkg::MASK_W-1:0] se_mask;
  int unsigned                row_pos;
  int unsigned                col_pos;
  mwe_pkg::result_t           minima_q [$];

  function automatic int unsigned fit_range(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // store one pixel and queue the window minimum it completes, if any
  task automatic erode_pixel(input mwe_pkg::pix_t px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      k;
    int unsigned      r;
    int unsigned      c;
    int unsigned      top;
    int unsigned      left;
    int unsigned      lowest;
    int unsigned      dy;
    int unsigned      dx;
    mwe_pkg::pix_t    p;
    mwe_pkg::result_t res;
    w = fit_range(img_width, 1, mwe_pkg::MAX_WIDTH);
    h = fit_range(img_height, 1, mwe_pkg::MAX_HEIGHT);
    k = fit_range(win_size, 1, mwe_pkg::MAX_KERNEL);
    r = row_pos;
    c = col_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    recent_lines[(r % mwe_pkg::MAX_KERNEL) * mwe_pkg::MAX_WIDTH + c] = px;

    if (r + 1 >= k && c + 1 >= k) begin
      top = r + 1 - k;
      left = c + 1 - k;
      lowest = 255;
      for (dy = 0; dy < k; dy++) begin
        for (dx = 0; dx < k; dx++) begin
          p = recent_lines[((top + dy) % mwe_pkg::MAX_KERNEL) * mwe_pkg::MAX_WIDTH +
                           left + dx];
          if (se_mask[dy * mwe_pkg::MAX_KERNEL + dx] && p < lowest) lowest = p;
        end
      end
      res.value = mwe_pkg::PIX_W'(lowest);
      res.top   = mwe_pkg::ROW_W'(top);
      res.left  = mwe_pkg::COL_W'(left);
      res.done  = (r == h - 1) && (c == w - 1);
      minima_q.insert(minima_q.size(), res);
    end

    // raster advance with frame wrap
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // compare one result request with the oldest expectation
  task automatic check_result();
    mwe_pkg::result_t want;
    if (minima_q.size() == 0) begin
      $error("unexpected result: eroded_value %0d out_row %0d out_col %0d frame_done %0d",
             eroded_value, out_row, out_col, frame_done);
      fail_count++;
    end else begin
      want = minima_q.pop_front();
      if (eroded_value !== want.value) begin
        $error("eroded_value: expected %0d, got %0d", want.value, eroded_value);
        fail_count++;
      end
      if (out_row !== want.top) begin
        $error("out_row: expected %0d, got %0d", want.top, out_row);
        fail_count++;
      end
      if (out_col !== want.left) begin
        $error("out_col: expected %0d, got %0d", want.left, out_col);
        fail_count++;
      end
      if (frame_done !== want.done) begin
        $error("frame_done: expected %0d, got %0d", want.done, frame_done);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      img_width  = 640;
      img_height = 480;
      win_size   = 3;
      se_mask    = '1;
      row_pos    = 0;
      col_pos    = 0;
      minima_q.delete();
      fail_count = 0;
    end else begin
      // register writes, geometry restarts the frame
      if (cfg_we) begin
        case (cfg_index)
          mwe_pkg::REG_IMAGE_WIDTH: begin
            img_width = cfg_data[mwe_pkg::IMGW_W-1:0];
            row_pos = 0;
            col_pos = 0;
          end
          mwe_pkg::REG_IMAGE_HEIGHT: begin
            img_height = cfg_data[mwe_pkg::IMGH_W-1:0];
            row_pos = 0;
            col_pos = 0;
          end
          mwe_pkg::REG_KERNEL_SIZE: begin
            win_size = cfg_data[mwe_pkg::KSZ_W-1:0];
            row_pos = 0;
            col_pos = 0;
          end
          mwe_pkg::REG_KERNEL_MASK: se_mask = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) erode_pixel(pixel);
      if (out_valid && !out_stall) check_result();
    end
    pending <= minima_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the erosion block with short directed frames, then random phases of
// geometry, mask and pixel content, with random gaps on the pixel side and
// random stalls on the result side. A checker beside the block predicts and
// compares every result request; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          LIMIT      = 400000;
  localparam int          RAND_ITEMS = 550;
  localparam int          RAND_SLACK = 40;
  localparam logic [mwe_pkg::MASK_W-1:0] FULL_MASK = '1;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [mwe_pkg::MASK_W-1:0] cfg_data;
  logic [mwe_pkg::PIX_W-1:0]  pixel;
  logic                       in_valid;
  logic                       in_stall;
  logic [mwe_pkg::PIX_W-1:0]  eroded_value;
  logic [mwe_pkg::ROW_W-1:0]  out_row;
  logic [mwe_pkg::COL_W-1:0]  out_col;
  logic                       frame_done;
  logic                       out_valid;
  logic                       out_stall;
  int                         fail_count;
  int                         pending;
  int                         cycles = 0;

  // current geometry as last written
  int unsigned cur_width  = 640;
  int unsigned cur_height = 480;
  bit          in_gaps    = 1'b1;
  bit          out_gaps   = 1'b1;
  int          random_items;
  int          phase;
  int unsigned frame_px;
  int unsigned burst;

  masked_window_erosion u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .eroded_value (eroded_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .frame_done   (frame_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

  mwe_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .eroded_value (eroded_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .frame_done   (frame_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall before each request
  initial begin
    int gap;
    out_stall <= 1'b1;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = out_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic int unsigned fit_range(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [mwe_pkg::MASK_W-1:0] pick_mask();
    logic [mwe_pkg::MASK_W-1:0] m;
    m = mwe_pkg::MASK_W'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0: m = '0;
      1: m = FULL_MASK;
      2: m = mwe_pkg::MASK_W'(1) << $urandom_range(0, mwe_pkg::MASK_W - 1);
      3: m = m & mwe_pkg::MASK_W'({$urandom, $urandom});
      default: ;
    endcase
    return m;
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 2047;
      2: return mwe_pkg::MAX_WIDTH;
      3: return $urandom_range(13, 16);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 8191;
      2: return mwe_pkg::MAX_HEIGHT;
      3: return mwe_pkg::MAX_HEIGHT - 1;
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  function automatic logic [mwe_pkg::PIX_W-1:0] pick_pixel();
    if ($urandom_range(0, 3) == 0) return mwe_pkg::PIX_W'($urandom_range(200, 255));
    return mwe_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  // one register write, write enable left high for back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [mwe_pkg::MASK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned k,
                           input logic [mwe_pkg::MASK_W-1:0] m);
    write_reg(mwe_pkg::REG_IMAGE_WIDTH, mwe_pkg::MASK_W'(w));
    write_reg(mwe_pkg::REG_IMAGE_HEIGHT, mwe_pkg::MASK_W'(h));
    write_reg(mwe_pkg::REG_KERNEL_SIZE, mwe_pkg::MASK_W'(k));
    write_reg(mwe_pkg::REG_KERNEL_MASK, m);
    cfg_we <= 1'b0;
    cur_width  = w & 11'h7FF;
    cur_height = h & 13'h1FFF;
  endtask

  task automatic write_mask(input logic [mwe_pkg::MASK_W-1:0] m);
    write_reg(mwe_pkg::REG_KERNEL_MASK, m);
    cfg_we <= 1'b0;
  endtask

  // pixel request with an optional gap in front
  task automatic send_pixel(input logic [mwe_pkg::PIX_W-1:0] px);
    int gap;
    gap = in_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel    <= px;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid, wait for all expected results and the pipeline to empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    cfg_we    <= 1'b0;
    cfg_index <= mwe_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    pixel     <= '0;
    in_valid  <= 1'b0;
    rst       <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // a few pixels under the reset geometry, no window completes
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'hAA);
    send_pixel(8'h55);
    settle();

    // 3x2 frame, 2x2 window, full mask, frame end on the second window
    configure(3, 2, 2, FULL_MASK);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    send_pixel(8'd1);
    send_pixel(8'd254);
    send_pixel(8'd127);
    settle();

    // empty mask gives 255, frame carries on without restart
    write_mask('0);
    for (int i = 0; i < 6; i++) send_pixel(mwe_pkg::PIX_W'(9 - i));
    settle();

    // only mask bits beyond the kernel set: still empty
    configure(1, 1, 1, mwe_pkg::MASK_W'(2));
    send_pixel(8'd0);
    settle();

    // one-pixel frame, every pixel is its own window and frame end
    write_mask(mwe_pkg::MASK_W'(1));
    send_pixel(8'd0);
    send_pixel(8'd255);
    settle();

    // window larger than the frame: no results at all
    configure(2, 2, 3, FULL_MASK);
    for (int i = 0; i < 4; i++) send_pixel(mwe_pkg::PIX_W'(i * 85));
    settle();

    // random phases
    random_items = 0;
    phase = 0;
    while (random_items < RAND_ITEMS) begin
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      case (phase)
        0: configure(0, 0, 0, pick_mask());
        1: configure(mwe_pkg::MAX_WIDTH, mwe_pkg::MAX_HEIGHT, 1, pick_mask());
        2: configure(7, 7, 7, pick_mask());
        3: configure(16, 8191, 7, FULL_MASK);
        4: configure(2047, 1, 1, pick_mask());
        default: begin
          if ($urandom_range(0, 5) == 0) write_mask(pick_mask());
          else configure(pick_width(), pick_height(), $urandom_range(0, 7), pick_mask());
        end
      endcase
      frame_px = fit_range(cur_width, 1, mwe_pkg::MAX_WIDTH) *
                 fit_range(cur_height, 1, mwe_pkg::MAX_HEIGHT);
      if (frame_px <= 120) begin
        burst = frame_px * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) burst += $urandom_range(0, frame_px - 1);
      end else if (fit_range(cur_width, 1, mwe_pkg::MAX_WIDTH) <= 16) begin
        burst = $urandom_range(100, 160);
      end else begin
        burst = $urandom_range(20, 60);
      end
      // keep the total close to the planned item count
      if (random_items + int'(burst) > RAND_ITEMS + RAND_SLACK) begin
        burst = $unsigned(RAND_ITEMS + RAND_SLACK - random_items);
      end
      for (int unsigned i = 0; i < burst; i++) send_pixel(pick_pixel());
      random_items += burst;
      phase++;
      settle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mwe_pkg.sv
rtl/mwe_line_buf.sv
rtl/mwe_min_tree.sv
rtl/masked_window_erosion.sv
bench/mwe_checker.sv
bench/tb_top.sv
